>>> hw/rtl/aspc_pkg.sv
// shared types, constants and codes for the averaged sensor pump controller
package aspc_pkg;

  // averaging window and sample geometry
  localparam int WINDOW      = 5;
  localparam int SAMPLE_W    = 10;
  localparam int SAMPLE_MAX  = 1023;
  localparam int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W       = $clog2(WINDOW * SAMPLE_MAX + 1);

  // divide by window: quotient estimate by reciprocal, then one correction
  localparam int AVG_SH      = SUM_W;
  localparam int AVG_RECIP_W = AVG_SH + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'((2 ** AVG_SH) / WINDOW);
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

  // mapping of averages to percent and tenths of a degree
  localparam int FULL_SCALE    = 1023;
  localparam int PCT_SCALE     = 100;
  localparam int TENTHS_SCALE  = 5000;
  localparam int TENTHS_OFFSET = 500;
  localparam int MAP_P_W       = 23;
  localparam int MAP_SH        = 23;
  localparam int MAP_RECIP_W   = 14;
  localparam logic [MAP_RECIP_W-1:0] MAP_RECIP = MAP_RECIP_W'((2 ** MAP_SH) / FULL_SCALE);
  localparam int MAP_PROD_W    = MAP_P_W + MAP_RECIP_W;
  localparam int QUOT_W        = 13;
  localparam int PCT_W         = 7;
  localparam int TENTHS_W      = 14;

  // exact temperature compares: tavg*500 against (deg+50)*1023
  localparam int DEG_W         = 19;
  localparam int DEG_SCALE     = 500;
  localparam int TEMP_OFFSET   = 50;
  localparam int TEMP_HIGH_REF = 110 * FULL_SCALE;

  localparam int TIME_W        = 32;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_LIMIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_DURATION     = 3'd4;

  // register reset values
  localparam logic [6:0]        RST_MOISTURE_LIMIT    = 7'd45;
  localparam logic [9:0]        RST_WATER_LIMIT       = 10'd200;
  localparam logic [5:0]        RST_TEMPERATURE_LIMIT = 6'd60;
  localparam logic [TIME_W-1:0] RST_CHECK_INTERVAL    = 32'd10000;
  localparam logic [TIME_W-1:0] RST_PUMP_DURATION     = 32'd5000;

  // display mode codes
  localparam logic [1:0] MODE_IRRIGATING = 2'd0;
  localparam logic [1:0] MODE_NO_WATER   = 2'd1;
  localparam logic [1:0] MODE_TEMP_HIGH  = 2'd2;
  localparam logic [1:0] MODE_NORMAL     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_RECIP,
    ST_AVG,
    ST_SCALE,
    ST_MAP,
    ST_FIX,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [6:0]        moisture_limit;
    logic [9:0]        water_limit;
    logic [5:0]        temperature_limit;
    logic [TIME_W-1:0] check_interval_ms;
    logic [TIME_W-1:0] pump_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic sum_en;
    logic recip_en;
    logic avg_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic scale_en;
    logic map_en;
    logic fix_en;
    logic decide_en;
  } merge_ctrl_t;

  typedef struct packed {
    logic [PCT_W-1:0]           moisture_percent;
    logic signed [TENTHS_W-1:0] temperature_tenths;
    logic [SAMPLE_W-1:0]        water_level;
    logic                       alert_lamp;
    logic                       pump_on;
    logic                       water_warning;
    logic [1:0]                 display_mode;
  } res_t;

endpackage

>>> hw/rtl/aspc_lane.sv
// one sensor channel: sample ring, ring sum and truncating average
module aspc_lane import aspc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  lane_ctrl_t          ctrl,
  input  logic [POS_W-1:0]    wr_pos,
  input  logic [SAMPLE_W-1:0] wr_data,
  output logic [SAMPLE_W-1:0] avg
);

  logic [SAMPLE_W-1:0]   ring [WINDOW];
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sum_next;
  logic [SUM_W-1:0]      quot_est;
  logic [AVG_PROD_W-1:0] prod;
  logic [SUM_W-1:0]      rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else if (ctrl.wr_en) begin
      ring[wr_pos] <= wr_data;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sum_next = sum_next + SUM_W'(ring[i]);
    end
  end

  // estimate is exact or one low
  assign prod = AVG_PROD_W'(sum) * AVG_PROD_W'(AVG_RECIP);
  assign rem  = sum - SUM_W'(quot_est * WINDOW);

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum <= sum_next;
    end
    if (ctrl.recip_en) begin
      quot_est <= prod[AVG_SH +: SUM_W];
    end
    if (ctrl.avg_en) begin
      avg <= SAMPLE_W'(quot_est + SUM_W'(rem >= SUM_W'(WINDOW)));
    end
  end

endmodule

>>> hw/rtl/aspc_merge.sv
// merge stage: unit mapping, limit compares and pump timing
module aspc_merge import aspc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  merge_ctrl_t         ctrl,
  input  cfg_t                cfg,
  input  logic [TIME_W-1:0]   now,
  input  logic [SAMPLE_W-1:0] avg_m,
  input  logic [SAMPLE_W-1:0] avg_t,
  input  logic [SAMPLE_W-1:0] avg_w,
  output res_t                res
);

  logic [MAP_P_W-1:0]    pm;
  logic [MAP_P_W-1:0]    pt;
  logic [MAP_PROD_W-1:0] prod_m;
  logic [MAP_PROD_W-1:0] prod_t;
  logic [QUOT_W-1:0]     qm;
  logic [QUOT_W-1:0]     qt;
  logic [MAP_P_W-1:0]    rm;
  logic [MAP_P_W-1:0]    rt;
  logic [PCT_W-1:0]      pct;
  logic [QUOT_W-1:0]     tenths_u;
  logic [DEG_W-1:0]      deg;
  logic [DEG_W-1:0]      deg_limit;
  logic                  temp_high;
  logic                  temp_ok;
  logic                  no_water;
  logic [SAMPLE_W-1:0]   water;
  logic                  check_due;
  logic                  run_elapsed;
  logic                  dur_zero;
  logic                  start;
  logic                  running_after;

  // pump state
  logic                  running;
  logic [TIME_W-1:0]     last_check_time;
  logic [TIME_W-1:0]     pump_start_time;

  assign deg       = DEG_W'(avg_t) * DEG_W'(DEG_SCALE);
  assign deg_limit = DEG_W'((32'(cfg.temperature_limit) + TEMP_OFFSET) * FULL_SCALE);

  always_ff @(posedge clk) begin
    if (ctrl.scale_en) begin
      pm        <= MAP_P_W'(avg_m) * MAP_P_W'(PCT_SCALE);
      pt        <= MAP_P_W'(avg_t) * MAP_P_W'(TENTHS_SCALE);
      temp_high <= deg > DEG_W'(TEMP_HIGH_REF);
      temp_ok   <= deg <= deg_limit;
      no_water  <= avg_w <= cfg.water_limit;
      water     <= avg_w;
    end
  end

  // divide by full scale: reciprocal estimate, then one correction
  assign prod_m = MAP_PROD_W'(pm) * MAP_PROD_W'(MAP_RECIP);
  assign prod_t = MAP_PROD_W'(pt) * MAP_PROD_W'(MAP_RECIP);
  assign rm     = pm - MAP_P_W'(qm * FULL_SCALE);
  assign rt     = pt - MAP_P_W'(qt * FULL_SCALE);

  always_ff @(posedge clk) begin
    if (ctrl.map_en) begin
      qm <= prod_m[MAP_SH +: QUOT_W];
      qt <= prod_t[MAP_SH +: QUOT_W];
    end
    if (ctrl.fix_en) begin
      pct         <= PCT_W'(qm + QUOT_W'(rm >= MAP_P_W'(FULL_SCALE)));
      tenths_u    <= qt + QUOT_W'(rt >= MAP_P_W'(FULL_SCALE));
      check_due   <= !running && ((now - last_check_time) >= cfg.check_interval_ms);
      run_elapsed <= (now - pump_start_time) >= cfg.pump_duration_ms;
      dur_zero    <= cfg.pump_duration_ms == '0;
    end
  end

  // a pump started now has zero elapsed time
  assign start         = check_due && (pct < cfg.moisture_limit) && !no_water && temp_ok;
  assign running_after = running ? !run_elapsed : (start && !dur_zero);

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      last_check_time <= '0;
      pump_start_time <= '0;
    end else if (ctrl.decide_en) begin
      running <= running_after;
      if (check_due) begin
        last_check_time <= now;
      end
      if (start) begin
        pump_start_time <= now;
      end
    end
  end

  always_comb begin
    res.moisture_percent   = pct;
    res.temperature_tenths = $signed({1'b0, tenths_u}) - $signed(TENTHS_W'(TENTHS_OFFSET));
    res.water_level        = water;
    res.alert_lamp         = no_water || temp_high;
    res.pump_on            = running_after;
    res.water_warning      = no_water;
    if (running_after) begin
      res.display_mode = MODE_IRRIGATING;
    end else if (no_water) begin
      res.display_mode = MODE_NO_WATER;
    end else if (temp_high) begin
      res.display_mode = MODE_TEMP_HIGH;
    end else begin
      res.display_mode = MODE_NORMAL;
    end
  end

endmodule

>>> hw/rtl/averaged_sensor_pump_controller.sv
// top level: sequencer, config registers, channel lanes, merge stage and result register
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_stall    | now_ms, raw_moisture, raw_temperature, raw_water
//  out      | out_valid / out_stall  | moisture_percent .. display_mode
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  an input transaction runs through 7 sequencer steps (ring sum, reciprocal
//  multiply, correction; scale, reciprocal multiply, correction; pump decision)
//  and then returns to idle, the only state in which a new item is taken
//  the three lanes run side by side; the single-item sequencer cannot take a
//  new item before the last one has left its decision step
//  reset clears the sample rings, ring position and pump state, and loads the
//  register defaults; no clearing pass is needed
//  a stalled result is held in the output register; the sequencer then waits in
//  its decision step until the register frees up
module averaged_sensor_pump_controller import aspc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TIME_W-1:0]          now_ms,
  input  logic [SAMPLE_W-1:0]        raw_moisture,
  input  logic [SAMPLE_W-1:0]        raw_temperature,
  input  logic [SAMPLE_W-1:0]        raw_water,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [PCT_W-1:0]           moisture_percent,
  output logic signed [TENTHS_W-1:0] temperature_tenths,
  output logic [SAMPLE_W-1:0]        water_level,
  output logic                       alert_lamp,
  output logic                       pump_on,
  output logic                       water_warning,
  output logic [1:0]                 display_mode,

  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [TIME_W-1:0]          cfg_data
);

  state_t            state;
  state_t            state_next;
  lane_ctrl_t        lane_ctrl;
  merge_ctrl_t       merge_ctrl;
  cfg_t              cfg;
  res_t              res;
  logic              in_accept;
  logic              out_free;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [TIME_W-1:0] now;
  logic [SAMPLE_W-1:0] avg_m;
  logic [SAMPLE_W-1:0] avg_t;
  logic [SAMPLE_W-1:0] avg_w;

  assign in_accept = in_valid && !in_stall;
  // result register can take a new value this cycle
  assign out_free  = !out_valid || !out_stall;

  // config writes are always taken; the user must write only while idle, which is not enforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.moisture_limit    <= RST_MOISTURE_LIMIT;
      cfg.water_limit       <= RST_WATER_LIMIT;
      cfg.temperature_limit <= RST_TEMPERATURE_LIMIT;
      cfg.check_interval_ms <= RST_CHECK_INTERVAL;
      cfg.pump_duration_ms  <= RST_PUMP_DURATION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOISTURE_LIMIT:    cfg.moisture_limit    <= cfg_data[6:0];
        REG_WATER_LIMIT:       cfg.water_limit       <= cfg_data[9:0];
        REG_TEMPERATURE_LIMIT: cfg.temperature_limit <= cfg_data[5:0];
        REG_CHECK_INTERVAL:    cfg.check_interval_ms <= cfg_data;
        REG_PUMP_DURATION:     cfg.pump_duration_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_SUM;
      ST_SUM:    state_next = ST_RECIP;
      ST_RECIP:  state_next = ST_AVG;
      ST_AVG:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_MAP;
      ST_MAP:    state_next = ST_FIX;
      ST_FIX:    state_next = ST_DECIDE;
      ST_DECIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall             = (state != ST_IDLE);
    lane_ctrl.wr_en      = in_valid && (state == ST_IDLE);
    lane_ctrl.sum_en     = (state == ST_SUM);
    lane_ctrl.recip_en   = (state == ST_RECIP);
    lane_ctrl.avg_en     = (state == ST_AVG);
    merge_ctrl.scale_en  = (state == ST_SCALE);
    merge_ctrl.map_en    = (state == ST_MAP);
    merge_ctrl.fix_en    = (state == ST_FIX);
    merge_ctrl.decide_en = (state == ST_DECIDE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared ring write position, wraps at the window length
  assign pos_next = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_accept) begin
      pos <= pos_next;
    end
  end

  // timestamp travels with the item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now <= now_ms;
    end
  end

  aspc_lane u_lane_moisture (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .wr_pos  (pos),
    .wr_data (raw_moisture),
    .avg     (avg_m)
  );

  aspc_lane u_lane_temperature (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .wr_pos  (pos),
    .wr_data (raw_temperature),
    .avg     (avg_t)
  );

  aspc_lane u_lane_water (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .wr_pos  (pos),
    .wr_data (raw_water),
    .avg     (avg_w)
  );

  aspc_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (merge_ctrl),
    .cfg   (cfg),
    .now   (now),
    .avg_m (avg_m),
    .avg_t (avg_t),
    .avg_w (avg_w),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (merge_ctrl.decide_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_ctrl.decide_en) begin
      moisture_percent   <= res.moisture_percent;
      temperature_tenths <= res.temperature_tenths;
      water_level        <= res.water_level;
      alert_lamp         <= res.alert_lamp;
      pump_on            <= res.pump_on;
      water_warning      <= res.water_warning;
      display_mode       <= res.display_mode;
    end
  end

  // an accepted transaction starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_SUM))
    else $error("accepted transaction did not start the sequencer");

  // a new result only appears out of the decision step
  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DECIDE))
    else $error("result appeared outside the decision step");

  // irrigating mode shown exactly when the pump runs
  a_mode_matches_pump: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pump_on == (display_mode == MODE_IRRIGATING)))
    else $error("display mode disagrees with pump state");

  // low water always lights the lamp
  a_warning_lamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && water_warning) |-> alert_lamp)
    else $error("water warning without alert lamp");

endmodule
